FILE: rtl/core/stpg_pkg.sv
// Shared types, constants and sine table builder for the sinusoid test pattern generator.
package stpg_pkg;

    localparam int PHASE_BITS    = 12;
    localparam int MAX_DIMENSION = 4096;

    localparam int COORD_W   = $clog2(MAX_DIMENSION);
    localparam int DIM_W     = 13;
    localparam int MODE_W    = 1;
    localparam int NB_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = DIM_W;

    localparam int QBITS    = PHASE_BITS - 2;
    localparam int QUARTER  = 1 << QBITS;
    localparam int QIDX_W   = QBITS + 1;
    localparam int SINE_W   = 15;
    localparam int DIV_STEPS = COORD_W + PHASE_BITS;

    localparam int QDEPTH   = 32;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(256);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(256);
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_W'(1);
    localparam logic [NB_W-1:0]  NB_RESET     = NB_W'(3);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned SINE_MAX    = 64'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_COLOR_MODE      = 3'd2,
        CFG_BYTES_PER_PIXEL = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
    } pixel_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] third_byte;
        logic [BYTE_W-1:0] fourth_byte;
        logic [NB_W-1:0]   valid_bytes;
    } pixel_out_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] col_phase;
        logic [PHASE_BITS-1:0] row_phase;
    } phase_pair_t;

    typedef logic [SINE_W-1:0] sine_table_t [0:QUARTER];

    // Quarter-wave sine in Q1.14 from a Taylor series in Q30 fixed point.
    function automatic logic [SINE_W-1:0] quarter_entry(longint unsigned r);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned h;
        longint unsigned v;
        a  = (r * HALF_PI_Q30) >> QBITS;
        x2 = (a * a) >> 30;
        h  = ONE_Q30 - x2 / 72;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 42;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 20;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 6;
        v  = (((a * h) >> 30) + (64'd1 << 15)) >> 16;
        if (v > SINE_MAX)
        begin
            v = SINE_MAX;
        end
        return SINE_W'(v);
    endfunction

    // The table is filled in blocks of 32 entries to keep each loop short.
    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        int unsigned idx;
        for (int unsigned hi = 0; hi <= (QUARTER >> 5); hi++)
        begin
            for (int unsigned lo = 0; lo < 32; lo++)
            begin
                idx = (hi << 5) + lo;
                if (idx <= QUARTER)
                begin
                    t[idx] = quarter_entry(longint'(idx));
                end
            end
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/stpg_phase_div.sv
// Pipelined restoring divider that turns a coordinate into a phase, one quotient bit per stage.
module stpg_phase_div
    import stpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [COORD_W-1:0]    coord,
    input  logic [DIM_W-1:0]      divisor,
    output logic                  out_valid,
    output logic [PHASE_BITS-1:0] phase
);

    logic [DIV_STEPS-1:0]  valid_reg;
    logic [DIM_W-1:0]      rem_reg  [DIV_STEPS];
    logic [COORD_W-1:0]    num_reg  [DIV_STEPS];
    logic [PHASE_BITS-1:0] quot_reg [DIV_STEPS];

    logic [DIM_W-1:0]      rem_next  [DIV_STEPS];
    logic                  qbit_next [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DIM_W-1:0]   rem_src;
        logic [COORD_W-1:0] num_src;
        logic [DIM_W:0]     trial;
        logic               fits;

        if (k == 0)
        begin : g_first
            assign rem_src = '0;
            assign num_src = coord;
        end
        else
        begin : g_later
            assign rem_src = rem_reg[k-1];
            assign num_src = num_reg[k-1];
        end

        // The dividend's low PHASE_BITS bits are zero; they enter as the coordinate shifts out.
        assign trial        = {rem_src, num_src[COORD_W-1]};
        assign fits         = trial >= {1'b0, divisor};
        assign rem_next[k]  = fits ? DIM_W'(trial - {1'b0, divisor}) : DIM_W'(trial);
        assign qbit_next[k] = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem_next[0];
        num_reg[0]  <= coord << 1;
        quot_reg[0] <= {{(PHASE_BITS-1){1'b0}}, qbit_next[0]};
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            num_reg[k]  <= num_reg[k-1] << 1;
            quot_reg[k] <= {quot_reg[k-1][PHASE_BITS-2:0], qbit_next[k]};
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign phase     = quot_reg[DIV_STEPS-1];

endmodule

FILE: rtl/core/stpg_front.sv
// Front part: admits pixels against queue credit and computes both phases.
module stpg_front
    import stpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  pixel_in_t   pixel,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    input  logic        queue_pop,
    output logic        phase_valid,
    output phase_pair_t phase_data
);

    logic [QCNT_W-1:0] pending_reg;
    logic [QCNT_W-1:0] pending_next;
    logic              accept;
    logic [DIM_W-1:0]  col_div;
    logic [DIM_W-1:0]  row_div;
    logic              col_valid;
    logic              row_valid;

    assign full   = pending_reg == QCNT_W'(QDEPTH);
    assign accept = push && !full;

    // A zero dimension divides as one.
    assign col_div = (image_width == '0) ? DIM_W'(1) : image_width;
    assign row_div = (image_height == '0) ? DIM_W'(1) : image_height;

    // Pending counts pixels in the divider pipeline plus those in the queue,
    // so the queue can never overflow.
    always_comb
    begin
        pending_next = pending_reg;
        if (accept && !queue_pop)
        begin
            pending_next = pending_reg + QCNT_W'(1);
        end
        else if (!accept && queue_pop)
        begin
            pending_next = pending_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    stpg_phase_div u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .coord     (pixel.pixel_column),
        .divisor   (col_div),
        .out_valid (col_valid),
        .phase     (phase_data.col_phase)
    );

    stpg_phase_div u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .coord     (pixel.pixel_row),
        .divisor   (row_div),
        .out_valid (row_valid),
        .phase     (phase_data.row_phase)
    );

    assign phase_valid = col_valid && row_valid;

endmodule

FILE: rtl/core/stpg_queue.sv
// Short queue of phase pairs between the front and back parts.
module stpg_queue
    import stpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  phase_pair_t wr_data,
    input  logic        rd_en,
    output logic        empty,
    output phase_pair_t rd_data
);

    phase_pair_t       entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign empty   = count_reg == '0;
    assign rd_data = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/stpg_sine_rom.sv
// Quarter-wave sine ROM with one registered read port.
module stpg_sine_rom
    import stpg_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [QIDX_W-1:0] rd_addr,
    output logic [SINE_W-1:0] rd_data
);

    localparam sine_table_t SINE_TABLE = build_sine_table();

    logic [SINE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= SINE_TABLE[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

FILE: rtl/core/stpg_back.sv
// Back part: sine lookups and byte formatting, with its own stall handling.
module stpg_back
    import stpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  phase_pair_t       queue_data,
    output logic              queue_pop,
    input  logic [MODE_W-1:0] color_mode,
    input  logic [NB_W-1:0]   bytes_per_pixel,
    output logic              empty,
    input  logic              pop,
    output pixel_out_t        result
);

    localparam int VAL_W  = SINE_W + 1;
    localparam int DIFF_W = SINE_W + 2;
    localparam int CHAN_W = SINE_W + 9;
    localparam int CHAN_SHIFT = SINE_W - 1;
    localparam int GRAY_SHIFT = 6;
    localparam logic signed [CHAN_W-1:0] CHAN_GAIN   = CHAN_W'(127);
    localparam logic signed [CHAN_W-1:0] CHAN_OFFSET = CHAN_W'(128) <<< CHAN_SHIFT;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = BYTE_W'(255);

    typedef struct packed {
        logic              neg;
        logic [QIDX_W-1:0] idx;
    } sine_addr_t;

    // Maps a phase onto a quarter-wave table index and a sign.
    function automatic sine_addr_t sine_addr(logic [PHASE_BITS-1:0] p);
        sine_addr_t a;
        logic [QBITS-1:0] m;
        m = p[QBITS-1:0];
        a.neg = p[PHASE_BITS-1];
        a.idx = p[PHASE_BITS-2] ? QIDX_W'(QUARTER) - QIDX_W'(m) : QIDX_W'(m);
        return a;
    endfunction

    function automatic logic signed [VAL_W-1:0] apply_sign(logic [SINE_W-1:0] mag, logic neg);
        logic signed [VAL_W-1:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic [BYTE_W-1:0] channel(logic signed [VAL_W-1:0] v);
        logic signed [CHAN_W-1:0] x;
        x = CHAN_W'(v) * CHAN_GAIN + CHAN_OFFSET;
        return x[CHAN_SHIFT+BYTE_W-1:CHAN_SHIFT];
    endfunction

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [2:0]  s1_neg_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    pixel_out_t  result_reg;
    pixel_out_t  result_next;

    logic        ready_out;
    logic        ready_s1;
    sine_addr_t  addr_t;
    sine_addr_t  addr_s;
    sine_addr_t  addr_c;
    logic [PHASE_BITS-1:0] cos_phase;
    logic [SINE_W-1:0] rom_t;
    logic [SINE_W-1:0] rom_s;
    logic [SINE_W-1:0] rom_c;

    assign ready_out = !out_valid_reg || pop;
    assign ready_s1  = !s1_valid_reg || ready_out;
    assign queue_pop = !queue_empty && ready_s1;

    // The cosine of the summed phase is the sine a quarter turn further on.
    assign cos_phase = queue_data.col_phase + queue_data.row_phase + PHASE_BITS'(QUARTER);
    assign addr_t    = sine_addr(queue_data.col_phase);
    assign addr_s    = sine_addr(queue_data.row_phase);
    assign addr_c    = sine_addr(cos_phase);

    stpg_sine_rom u_rom_t (
        .clk     (clk),
        .rd_en   (ready_s1),
        .rd_addr (addr_t.idx),
        .rd_data (rom_t)
    );

    stpg_sine_rom u_rom_s (
        .clk     (clk),
        .rd_en   (ready_s1),
        .rd_addr (addr_s.idx),
        .rd_data (rom_s)
    );

    stpg_sine_rom u_rom_c (
        .clk     (clk),
        .rd_en   (ready_s1),
        .rd_addr (addr_c.idx),
        .rd_data (rom_c)
    );

    always_comb
    begin
        s1_valid_next  = ready_s1 ? queue_pop : s1_valid_reg;
        out_valid_next = ready_out ? s1_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        logic signed [VAL_W-1:0]  sin_t;
        logic signed [VAL_W-1:0]  sin_s;
        logic signed [VAL_W-1:0]  cos_ts;
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        logic [DIFF_W-1:0]        quo;
        logic [BYTE_W-1:0]        gray;
        logic [NB_W-1:0]          nb;
        logic [BYTE_W-1:0]        b0;
        logic [BYTE_W-1:0]        b1;
        logic [BYTE_W-1:0]        b2;
        logic [BYTE_W-1:0]        b3;

        sin_t  = apply_sign(rom_t, s1_neg_reg[0]);
        sin_s  = apply_sign(rom_s, s1_neg_reg[1]);
        cos_ts = apply_sign(rom_c, s1_neg_reg[2]);

        // Gray is the difference divided by 64, truncated toward zero.
        diff = DIFF_W'(sin_t) - DIFF_W'(sin_s);
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        quo  = mag >> GRAY_SHIFT;
        gray = diff[DIFF_W-1] ? BYTE_W'(-quo) : BYTE_W'(quo);

        priority if (bytes_per_pixel == '0)
        begin
            nb = NB_W'(1);
        end
        else if (bytes_per_pixel > NB_W'(4))
        begin
            nb = NB_W'(4);
        end
        else
        begin
            nb = bytes_per_pixel;
        end

        if (color_mode != '0)
        begin
            b0 = channel(sin_t);
            b1 = channel(cos_ts);
            b2 = channel(sin_s);
            b3 = ALPHA_OPAQUE;
        end
        else
        begin
            b0 = gray;
            b1 = gray;
            b2 = gray;
            b3 = gray;
        end

        result_next.first_byte  = b0;
        result_next.second_byte = (nb > NB_W'(1)) ? b1 : '0;
        result_next.third_byte  = (nb > NB_W'(2)) ? b2 : '0;
        result_next.fourth_byte = (nb > NB_W'(3)) ? b3 : '0;
        result_next.valid_bytes = nb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_s1)
        begin
            s1_neg_reg <= {addr_c.neg, addr_s.neg, addr_t.neg};
        end
        if (ready_out && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/sinusoid_test_pattern_generator.sv
// Top level of the sinusoid test pattern generator: configuration registers and part wiring.
//
// Input channel: a pixel coordinate (column, row) is transferred when push is high and
// full is low. Result channel: the pixel's bytes are on result while empty is low and
// are transferred when pop is high.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index (image
// width, image height, color mode, bytes per pixel); indexes above three are ignored.
// Write configuration only while no pixel is in flight.
// A pixel passes through the phase dividers, 24 stages (one quotient bit per stage),
// then the phase queue, the registered sine ROM read and the output register.
// Throughput: one pixel per cycle, sustained while the receiver keeps popping.
// A 32-entry phase queue sits between the dividers and the sine stage. Input credit
// covers both the divider pipeline and the queue, so once the receiver has stopped
// taking results full rises with 34 pixels held inside (32 in the dividers and queue,
// two in the sine and output stages); nothing is dropped.
// Reset clears the pipeline valid flags and the queue pointers and counts (data registers
// are not reset) and loads width 256, height 256, color mode and three bytes per pixel.
module sinusoid_test_pattern_generator
    import stpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pixel_in_t            pixel,
    output logic                 empty,
    input  logic                 pop,
    output pixel_out_t           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  width_next;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  height_next;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic [NB_W-1:0]   nb_reg;
    logic [NB_W-1:0]   nb_next;

    logic        phase_valid;
    phase_pair_t phase_data;
    logic        queue_pop;
    logic        queue_empty;
    phase_pair_t queue_data;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        nb_next     = nb_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:     width_next  = cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    height_next = cfg_data[DIM_W-1:0];
                CFG_COLOR_MODE:      mode_next   = cfg_data[MODE_W-1:0];
                CFG_BYTES_PER_PIXEL: nb_next     = cfg_data[NB_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            mode_reg   <= MODE_RESET;
            nb_reg     <= NB_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
            nb_reg     <= nb_next;
        end
    end

    stpg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .queue_pop    (queue_pop),
        .phase_valid  (phase_valid),
        .phase_data   (phase_data)
    );

    stpg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (phase_valid),
        .wr_data (phase_data),
        .rd_en   (queue_pop),
        .empty   (queue_empty),
        .rd_data (queue_data)
    );

    stpg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .queue_data      (queue_data),
        .queue_pop       (queue_pop),
        .color_mode      (mode_reg),
        .bytes_per_pixel (nb_reg),
        .empty           (empty),
        .pop             (pop),
        .result          (result)
    );

endmodule

FILE: rtl/core/stpg_checker.sv
// Port-level checks for the sinusoid test pattern generator, bound to the top level.
module stpg_checker
    import stpg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input pixel_out_t result
);

    // A waiting result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed before its transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.valid_bytes >= NB_W'(1) && result.valid_bytes <= NB_W'(4))
    else $error("valid_bytes out of range");

    // The fourth byte is zero on a pixel narrower than four bytes, in both modes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.valid_bytes < NB_W'(4) |-> result.fourth_byte == '0)
    else $error("fourth byte set on a narrow pixel");

    assert property (@(posedge clk)
        !rst_n |-> !full && empty)
    else $error("queue flags not cleared by reset");

endmodule

bind sinusoid_test_pattern_generator stpg_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

FILE: bench/testbench.sv
// Self-checking testbench for the sinusoid test pattern generator.
`timescale 1ns / 1ps

module testbench;
    import stpg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;
    localparam int IDLE_PERCENT = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 150;
    localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_BITS) - 1;

    // Predicts each pixel from the register copy and keeps the pixels still owed.
    class pixel_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic             mode_reg;
        logic [NB_W-1:0]  bpp_reg;
        pixel_out_t       owed[$];
        int               errors;

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mode_reg = MODE_RESET;
            bpp_reg = NB_RESET;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:     width_reg = data;
                CFG_IMAGE_HEIGHT:    height_reg = data;
                CFG_COLOR_MODE:      mode_reg = data[0];
                CFG_BYTES_PER_PIXEL: bpp_reg = data[NB_W-1:0];
                default:             ;
            endcase
        endfunction

        // Taylor series of sin(r * pi/2 / QUARTER) in Q30, rounded to Q1.14.
        function longint unsigned taylor_quarter(longint unsigned r);
            longint unsigned ang;
            longint unsigned sq;
            longint unsigned acc;
            longint unsigned val;
            ang = (r * 64'd1686629713) >> QBITS;
            sq = (ang * ang) >> 30;
            acc = (64'd1 << 30) - sq / 72;
            acc = (64'd1 << 30) - ((sq * acc) >> 30) / 42;
            acc = (64'd1 << 30) - ((sq * acc) >> 30) / 20;
            acc = (64'd1 << 30) - ((sq * acc) >> 30) / 6;
            val = (((ang * acc) >> 30) + (64'd1 << 15)) >> 16;
            if (val > 64'd16384)
            begin
                val = 64'd16384;
            end
            return val;
        endfunction

        function int sine_at(longint unsigned p);
            longint unsigned quad;
            longint unsigned rest;
            p = p & PHASE_MASK;
            quad = p >> QBITS;
            rest = p & (QUARTER - 1);
            case (quad)
                0:       return int'(taylor_quarter(rest));
                1:       return int'(taylor_quarter(QUARTER - rest));
                2:       return -int'(taylor_quarter(rest));
                default: return -int'(taylor_quarter(QUARTER - rest));
            endcase
        endfunction

        function longint unsigned phase_of(logic [COORD_W-1:0] pos, logic [DIM_W-1:0] dim);
            longint unsigned num;
            longint unsigned den;
            num = longint'(pos) << PHASE_BITS;
            den = (dim == 0) ? 64'd1 : longint'(dim);
            return (num / den) & PHASE_MASK;
        endfunction

        function logic [BYTE_W-1:0] channel_byte(int v);
            int x;
            x = 127 * v + 128 * 16384;
            return BYTE_W'(x >> 14);
        endfunction

        function pixel_out_t predict_pixel(pixel_in_t px);
            pixel_out_t       res;
            longint unsigned  pt;
            longint unsigned  ps;
            int               st;
            int               ss;
            int               diff;
            int               mag;
            logic [NB_W-1:0]  nb;
            logic [BYTE_W-1:0] b [4];
            pt = phase_of(px.pixel_column, width_reg);
            ps = phase_of(px.pixel_row, height_reg);
            st = sine_at(pt);
            ss = sine_at(ps);
            nb = bpp_reg;
            if (nb == 0)
            begin
                nb = 1;
            end
            if (nb > 4)
            begin
                nb = 4;
            end
            if (mode_reg)
            begin
                b[0] = channel_byte(st);
                b[1] = channel_byte(sine_at(pt + ps + QUARTER));
                b[2] = channel_byte(ss);
                b[3] = 8'd255;
            end
            else
            begin
                // Gray level is the sine difference divided by 64, rounded toward zero.
                diff = st - ss;
                mag = ((diff < 0) ? -diff : diff) >> 6;
                b[0] = BYTE_W'((diff < 0) ? -mag : mag);
                b[1] = b[0];
                b[2] = b[0];
                b[3] = b[0];
            end
            res.first_byte = b[0];
            res.second_byte = (nb > 1) ? b[1] : 8'd0;
            res.third_byte = (nb > 2) ? b[2] : 8'd0;
            res.fourth_byte = (nb > 3) ? b[3] : 8'd0;
            res.valid_bytes = nb;
            return res;
        endfunction

        function void note_pixel(pixel_in_t px);
            owed.push_back(predict_pixel(px));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_out_t got);
            pixel_out_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare_field("first_byte", want.first_byte, got.first_byte);
            compare_field("second_byte", want.second_byte, got.second_byte);
            compare_field("third_byte", want.third_byte, got.third_byte);
            compare_field("fourth_byte", want.fourth_byte, got.fourth_byte);
            compare_field("valid_bytes", want.valid_bytes, got.valid_bytes);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push = 1'b0;
    logic                 full;
    pixel_in_t            pixel = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    pixel_out_t           result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    bit steady = 1'b0;
    bit hold_req = 1'b0;

    pixel_scoreboard scoreboard = new();

    sinusoid_test_pattern_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random pop gaps, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                scoreboard.check_pixel(result);
            end
        end
    end

    // The input side goes idle first so no further pixel is transferred while draining.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (scoreboard.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        scoreboard.write_register(idx, data);
    endtask

    task automatic set_config(int unsigned w, int unsigned h, int unsigned mode,
                              int unsigned bpp);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(CFG_COLOR_MODE, CFG_W'(mode));
        write_reg(CFG_BYTES_PER_PIXEL, CFG_W'(bpp));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        pixel <= '{pixel_column: col, pixel_row: row};
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        scoreboard.note_pixel(pixel);
    endtask

    // Mostly positions inside the image, the rest anywhere in the coordinate range.
    function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim);
        int unsigned lim;
        lim = (dim == 0) ? 1 : ((dim > 4096) ? 4096 : dim);
        if ($urandom_range(0, 99) < 85)
        begin
            return COORD_W'($urandom_range(0, lim - 1));
        end
        return COORD_W'($urandom_range(0, 4095));
    endfunction

    task automatic run_random(int unsigned w, int unsigned h, int unsigned mode,
                              int unsigned bpp, int unsigned count);
        set_config(w, h, mode, bpp);
        repeat (count)
        begin
            send_pixel(pick_coord(w), pick_coord(h));
        end
    endtask

    initial
    begin
        logic [COORD_W-1:0] corner_cols [12];
        logic [COORD_W-1:0] corner_rows [12];
        rst_n <= 1'b0;
        corner_cols = '{0, 64, 128, 192, 255, 0, 0, 0, 64, 4095, 0, 4095};
        corner_rows = '{0, 0, 0, 0, 255, 64, 128, 192, 192, 0, 4095, 4095};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Quadrant edges and coordinate extremes, first under the reset settings.
        for (int i = 0; i < 12; i++)
        begin
            send_pixel(corner_cols[i], corner_rows[i]);
        end
        wait_drained();
        write_reg(CFG_SPARE_INDEX, '1);
        set_config(1024, 1024, 0, 4);
        for (int i = 0; i < 12; i++)
        begin
            send_pixel(corner_cols[i], corner_rows[i]);
        end

        steady = 1'b1;
        run_random(4096, 4096, 0, 2, 60);
        steady = 1'b0;
        run_random(1, 1, 1, 4, 40);
        run_random(8191, 8191, 1, 0, 50);
        run_random(0, 0, 0, 7, 40);

        // The receiver stops for a while so the block fills and pushes back.
        wait_drained();
        hold_req = 1'b1;
        run_random(640, 480, 1, 3, 100);

        repeat (6)
        begin
            run_random($urandom_range(1, 4096), $urandom_range(1, 4096),
                       $urandom_range(0, 1), $urandom_range(0, 7), 60);
        end

        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        if (scoreboard.errors == 0 && scoreboard.owed.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/stpg_pkg.sv
rtl/core/stpg_phase_div.sv
rtl/core/stpg_front.sv
rtl/core/stpg_queue.sv
rtl/core/stpg_sine_rom.sv
rtl/core/stpg_back.sv
rtl/core/sinusoid_test_pattern_generator.sv
rtl/core/stpg_checker.sv
bench/testbench.sv
